### design/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds on every enabled clock edge
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

### design/qnmr_pkg.sv
`timescale 1ns / 1ps

package qnmr_pkg;

   // field widths
   localparam int LANES      = 4;
   localparam int ACT_W      = 8;
   localparam int WGT_W      = 8;
   localparam int PROD_W     = ACT_W + 1 + WGT_W;
   localparam int DOT_W      = 18;
   localparam int SLOT_W     = 3;
   localparam int SLOT_SPACE = 1 << SLOT_W;
   localparam int BIAS_W     = 16;
   localparam int ACC_W      = 32;
   localparam int OUT_W      = 8;
   localparam int SHIFT_W    = 5;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_AMOUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELU_ENABLE  = 2'd1;
   localparam logic [SHIFT_W-1:0]   SHIFT_RESET      = 5'd8;
   localparam logic                 RELU_RESET       = 1'b1;

   // decoupling queue
   localparam int QUEUE_DEPTH = 4;

   // one classified item between front and back
   typedef struct packed {
      logic signed [DOT_W-1:0]  dot;
      logic [SLOT_W-1:0]        slot;
      logic                     first_item;
      logic                     last_item;
      logic signed [BIAS_W-1:0] bias_value;
   } mac_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [SHIFT_W-1:0] shift_amount;
      logic               relu_enable;
   } csr_regs_type;

endpackage

### design/qnmr_if.sv
`timescale 1ns / 1ps

// input channel
interface qnmr_req_if import qnmr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ACT_W-1:0]        act_lane0;
   logic [ACT_W-1:0]        act_lane1;
   logic [ACT_W-1:0]        act_lane2;
   logic [ACT_W-1:0]        act_lane3;
   logic signed [WGT_W-1:0] wgt_lane0;
   logic signed [WGT_W-1:0] wgt_lane1;
   logic signed [WGT_W-1:0] wgt_lane2;
   logic signed [WGT_W-1:0] wgt_lane3;
   logic [SLOT_W-1:0]       acc_slot;
   logic                    first_item;
   logic                    last_item;
   logic signed [BIAS_W-1:0] bias_value;

   modport source (output valid, act_lane0, act_lane1, act_lane2, act_lane3,
                   wgt_lane0, wgt_lane1, wgt_lane2, wgt_lane3, acc_slot,
                   first_item, last_item, bias_value, input ready);
   modport sink (input valid, act_lane0, act_lane1, act_lane2, act_lane3,
                 wgt_lane0, wgt_lane1, wgt_lane2, wgt_lane3, acc_slot,
                 first_item, last_item, bias_value, output ready);
endinterface

// result channel
interface qnmr_rsp_if import qnmr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OUT_W-1:0]  out_value;
   logic [SLOT_W-1:0] out_slot;

   modport source (output valid, out_value, out_slot, input ready);
   modport sink (input valid, out_value, out_slot, output ready);
endinterface

// configuration write channel
interface qnmr_csr_if import qnmr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### design/qnmr_front.sv
`timescale 1ns / 1ps

module qnmr_front import qnmr_pkg::*; #(
   parameter int NUM_SLOTS = 8
) (
   input  logic         clock,
   input  logic         reset,
   qnmr_req_if.sink     req_chan,
   output logic         out_valid,
   input  logic         out_ready,
   output mac_item_type out_item
);

   logic [ACT_W-1:0]         act [LANES];
   logic signed [WGT_W-1:0]  wgt [LANES];
   logic signed [PROD_W-1:0] prod [LANES];
   logic signed [DOT_W-1:0]  dot_in;
   logic                     slot_ok;
   logic                     accept;
   logic                     valid_ff;
   mac_item_type             item_in;
   mac_item_type             item_ff;

   assign act[0] = req_chan.act_lane0;
   assign act[1] = req_chan.act_lane1;
   assign act[2] = req_chan.act_lane2;
   assign act[3] = req_chan.act_lane3;
   assign wgt[0] = req_chan.wgt_lane0;
   assign wgt[1] = req_chan.wgt_lane1;
   assign wgt[2] = req_chan.wgt_lane2;
   assign wgt[3] = req_chan.wgt_lane3;

   // four lane products, activation zero-extended into a signed operand
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         prod[i] = PROD_W'($signed({1'b0, act[i]}) * wgt[i]);
      end
   end

   assign dot_in = DOT_W'(prod[0]) + DOT_W'(prod[1]) + DOT_W'(prod[2]) + DOT_W'(prod[3]);

   // slots past the configured count are dropped here
   assign slot_ok = (32'(req_chan.acc_slot) < 32'(NUM_SLOTS));

   assign req_chan.ready = !valid_ff || out_ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      item_in.dot        = dot_in;
      item_in.slot       = req_chan.acc_slot;
      item_in.first_item = req_chan.first_item;
      item_in.last_item  = req_chan.last_item;
      item_in.bias_value = req_chan.bias_value;
   end

   // classification register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         valid_ff <= accept && slot_ok;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### design/qnmr_queue.sv
`timescale 1ns / 1ps

module qnmr_queue import qnmr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  mac_item_type     push_item,
   output logic             pop_valid,
   input  logic             pop_ready,
   output mac_item_type     pop_item,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   mac_item_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push;
   logic             pop;

   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign push_ready   = !status.full;
   assign pop_valid    = !status.empty;
   assign push         = push_valid && push_ready;
   assign pop          = pop_valid && pop_ready;
   assign pop_item     = entry_ff[rd_ptr_ff];

   // pointers wrap over a power-of-two depth
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### design/qnmr_back.sv
`timescale 1ns / 1ps

module qnmr_back import qnmr_pkg::*; #(
   parameter int NUM_SLOTS = 8,
   parameter int OUT_BITS  = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  mac_item_type in_item,
   input  csr_regs_type regs,
   qnmr_rsp_if.source   rsp_chan
);

   localparam int ACC_DEPTH = (NUM_SLOTS < SLOT_SPACE) ? NUM_SLOTS : SLOT_SPACE;
   localparam int IDX_W     = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
   localparam logic signed [ACC_W-1:0] OUT_HI = ACC_W'((64'd1 << OUT_BITS) - 64'd1);

   logic [ACC_W-1:0]         acc_ff [ACC_DEPTH];
   logic [IDX_W-1:0]         idx;
   logic [ACC_W-1:0]         acc_sum_in;
   logic                     adv;
   logic                     pop;

   logic                     b_valid_ff;
   logic [ACC_W-1:0]         b_acc_ff;
   logic signed [BIAS_W-1:0] b_bias_ff;
   logic [SLOT_W-1:0]        b_slot_ff;
   logic signed [ACC_W-1:0]  biased_in;
   logic signed [ACC_W-1:0]  rect_in;

   logic                     c_valid_ff;
   logic signed [ACC_W-1:0]  c_sum_ff;
   logic [SLOT_W-1:0]        c_slot_ff;
   logic signed [ACC_W-1:0]  shifted_in;
   logic signed [ACC_W-1:0]  clamp_in;

   logic                     out_valid_ff;
   logic [OUT_W-1:0]         out_value_ff;
   logic [SLOT_W-1:0]        out_slot_ff;

   // whole back pipe moves when the output register can take a value
   assign adv      = !out_valid_ff || rsp_chan.ready;
   assign in_ready = adv;
   assign pop      = in_valid && adv;
   assign idx      = in_item.slot[IDX_W-1:0];

   // read-modify-write of the addressed slot, first mark starts from zero
   assign acc_sum_in = (in_item.first_item ? '0 : acc_ff[idx]) + ACC_W'(in_item.dot);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ACC_DEPTH; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (pop) begin
         acc_ff[idx] <= acc_sum_in;
      end
   end

   // bias add and rectifier
   assign biased_in = $signed(b_acc_ff + ACC_W'(b_bias_ff));
   assign rect_in   = (regs.relu_enable && (biased_in <= 0)) ? '0 : biased_in;

   // arithmetic shift and clamp to the output range
   assign shifted_in = c_sum_ff >>> regs.shift_amount;
   always_comb begin
      if (shifted_in < 0) begin
         clamp_in = '0;
      end else if (shifted_in > OUT_HI) begin
         clamp_in = OUT_HI;
      end else begin
         clamp_in = shifted_in;
      end
   end

   // stage registers, only last items carry a valid result
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff   <= pop && in_item.last_item;
         c_valid_ff   <= b_valid_ff;
         out_valid_ff <= c_valid_ff;
      end
      if (adv) begin
         b_acc_ff     <= acc_sum_in;
         b_bias_ff    <= in_item.bias_value;
         b_slot_ff    <= in_item.slot;
         c_sum_ff     <= rect_in;
         c_slot_ff    <= b_slot_ff;
         out_value_ff <= clamp_in[OUT_W-1:0];
         out_slot_ff  <= c_slot_ff;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_value = out_value_ff;
   assign rsp_chan.out_slot  = out_slot_ff;

endmodule

### design/quantized_neuron_mac_requantize.sv
`timescale 1ns / 1ps
// channel    direction  handshake    payload
// req_chan   in         valid/ready  act_lane0..3, wgt_lane0..3, acc_slot, first/last, bias
// rsp_chan   out        valid/ready  out_value, out_slot
// csr_chan   in         valid/ready  index, data (0 shift_amount, 1 relu_enable)
//
// one transaction per cycle sustained while rsp_chan is not stalled; the accumulate
// slot read-modify-write writes back at the popping edge; same-slot items do not wait
// a result is offered once the last-marked transaction has passed the front reg (at the
// accepting edge), then the queue, accumulate, bias/rectifier and shift/clamp output reg
// synchronous reset clears all slot accumulators in parallel, no clearing pass
// a stalled rsp_chan holds the back end; the four-entry queue lets the front keep
// taking transactions until it fills

`include "assert_macros.svh"

module quantized_neuron_mac_requantize import qnmr_pkg::*; #(
   parameter int NUM_SLOTS = 8,
   parameter int OUT_BITS  = 8
) (
   input  logic       clock,
   input  logic       reset,
   qnmr_req_if.sink   req_chan,
   qnmr_rsp_if.source rsp_chan,
   qnmr_csr_if.sink   csr_chan
);

   localparam int OUT_HI_INT = (1 << OUT_BITS) - 1;

   csr_regs_type     csr_ff;
   logic             f_valid;
   logic             q_push_ready;
   mac_item_type     f_item;
   logic             q_pop_valid;
   logic             q_pop_ready;
   mac_item_type     q_item;
   queue_status_type q_status;

   // configuration registers
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.shift_amount <= SHIFT_RESET;
         csr_ff.relu_enable  <= RELU_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_SHIFT_AMOUNT: csr_ff.shift_amount <= csr_chan.data[SHIFT_W-1:0];
            CSR_RELU_ENABLE:  csr_ff.relu_enable  <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

   qnmr_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (f_valid),
      .out_ready (q_push_ready),
      .out_item  (f_item)
   );

   qnmr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (q_push_ready),
      .push_item  (f_item),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_item   (q_item),
      .status     (q_status)
   );

   qnmr_back #(.NUM_SLOTS(NUM_SLOTS), .OUT_BITS(OUT_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_pop_valid),
      .in_ready (q_pop_ready),
      .in_item  (q_item),
      .regs     (csr_ff),
      .rsp_chan (rsp_chan)
   );

   // checks
   `ASSERT_ALWAYS(queue_full_empty_excl, clock, reset, !(q_status.full && q_status.empty))
   `ASSERT_IMPLIES(no_accept_when_blocked, clock, reset, f_valid && !q_push_ready, !(req_chan.valid && req_chan.ready))
   `ASSERT_IMPLIES(pop_only_when_filled, clock, reset, q_pop_valid, !q_status.empty)
   `ASSERT_IMPLIES(rsp_value_in_range, clock, reset, rsp_chan.valid, 32'(rsp_chan.out_value) <= 32'(OUT_HI_INT))

endmodule
